// ===== rtl/wbsa_pkg.sv =====
// Package for the weighted block scatter-accumulate unit.
// Holds field widths, operation and command codes and default sizes.
// No dependencies; every other file refers to it by scoped names.
package wbsa_pkg;

	// Default number of groups (side of the accumulator matrix).
	localparam int MAX_GROUPS_DEF = 64;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Field widths.
	localparam int OP_W     = 2;
	localparam int GROUP_W  = 6;
	localparam int SIZE_W   = 7;
	localparam int FACTOR_W = 32;
	localparam int VAL_W    = 64;

	// Reset value of the matrix size register.
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	// Operation codes of an input item; the unused code acts as a read.
	localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Command carried from the front to the back.
	typedef enum logic [1:0] {
		CMD_ACC,
		CMD_WRITE,
		CMD_READ,
		CMD_ERR
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	// Signed saturation limits of an entry.
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

// ===== rtl/wbsa_if.sv =====
// Channel interfaces of the weighted block scatter-accumulate unit.
// Valid/ready handshake with the item payload; widths from wbsa_pkg.
interface wbsa_in_if;
	logic                                valid;
	logic                                ready;
	logic [wbsa_pkg::OP_W-1:0]           operation;
	logic [wbsa_pkg::GROUP_W-1:0]        row_group;
	logic [wbsa_pkg::GROUP_W-1:0]        col_group;
	logic signed [wbsa_pkg::FACTOR_W-1:0] weight;
	logic signed [wbsa_pkg::FACTOR_W-1:0] coefficient;
	logic signed [wbsa_pkg::VAL_W-1:0]   load_value;

	modport source (
		output valid, operation, row_group, col_group, weight, coefficient, load_value,
		input  ready
	);
	modport sink (
		input  valid, operation, row_group, col_group, weight, coefficient, load_value,
		output ready
	);
endinterface

interface wbsa_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [wbsa_pkg::VAL_W-1:0] entry_value;
	logic                              saturated;
	logic                              index_error;

	modport source (
		output valid, entry_value, saturated, index_error,
		input  ready
	);
	modport sink (
		input  valid, entry_value, saturated, index_error,
		output ready
	);
endinterface

// ===== rtl/wbsa_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Generic width; depth taken from wbsa_pkg::QUEUE_DEPTH (a power of two).
module wbsa_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] head
);

	localparam int DEPTH = wbsa_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/wbsa_front.sv =====
// Front of the scatter-accumulate unit: holds the matrix size register,
// checks indices, forms the address and the product, and fills the queue.
// Depends on wbsa_pkg and the wbsa_in_if interface.
module wbsa_front #(
	parameter int MAX_GROUPS = wbsa_pkg::MAX_GROUPS_DEF,
	parameter int AW         = 12,
	parameter int EW         = 78
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wbsa_pkg::SIZE_W-1:0] cfg_wdata,
	wbsa_in_if.sink                     in_ch,
	input  logic                        clearing,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [EW-1:0]               q_data
);

	logic [wbsa_pkg::SIZE_W-1:0]       matrix_size_q;
	logic                              row_ok;
	logic                              col_ok;
	logic [AW-1:0]                     addr;
	logic signed [wbsa_pkg::VAL_W-1:0] product;
	logic [wbsa_pkg::VAL_W-1:0]        operand;
	wbsa_pkg::cmd_t                    cmd;

	// Matrix size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= wbsa_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	// An index must lie below both the configured size and the matrix side.
	assign row_ok = ({1'b0, in_ch.row_group} < matrix_size_q) &&
		(32'(in_ch.row_group) < MAX_GROUPS);
	assign col_ok = ({1'b0, in_ch.col_group} < matrix_size_q) &&
		(32'(in_ch.col_group) < MAX_GROUPS);

	// Row-major address with a fixed stride of the matrix side.
	assign addr = AW'(in_ch.row_group) * AW'(MAX_GROUPS) + AW'(in_ch.col_group);

	// Exact Q24.40 product of the Q16.16 weight and the Q8.24 coefficient.
	assign product = in_ch.weight * in_ch.coefficient;

	// Classify the item.
	always_comb begin
		cmd     = wbsa_pkg::CMD_READ;
		operand = in_ch.load_value;
		if (!(row_ok && col_ok)) begin
			cmd = wbsa_pkg::CMD_ERR;
		end else begin
			case (in_ch.operation)
				wbsa_pkg::OP_ACC: begin
					cmd     = wbsa_pkg::CMD_ACC;
					operand = product;
				end
				wbsa_pkg::OP_WRITE: begin
					cmd = wbsa_pkg::CMD_WRITE;
				end
				default: begin
					cmd = wbsa_pkg::CMD_READ;
				end
			endcase
		end
	end

	// Items are taken whenever the queue has room and the memory is cleared.
	assign in_ch.ready = !q_full && !clearing;
	assign q_push      = in_ch.valid && in_ch.ready;
	assign q_data      = {cmd, addr, operand};

endmodule

// ===== rtl/wbsa_back.sv =====
// Back of the scatter-accumulate unit: the accumulator memory, its clearing
// pass after reset, the read-modify-write sequencer and the result register.
// Depends on wbsa_pkg and the wbsa_out_if interface.
module wbsa_back #(
	parameter int MAX_GROUPS = wbsa_pkg::MAX_GROUPS_DEF,
	parameter int AW         = 12,
	parameter int EW         = 78
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [EW-1:0] q_head,
	output logic          q_pop,
	output logic          clearing,
	wbsa_out_if.source    out_ch
);

	localparam int DEPTH = MAX_GROUPS * MAX_GROUPS;
	localparam int VW    = wbsa_pkg::VAL_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_addr_q;
	wbsa_pkg::cmd_t             cmd_q;
	logic [AW-1:0]              addr_q;
	logic [VW-1:0]              operand_q;
	logic [VW-1:0]              rd_data_q;
	logic [VW-1:0]              mem [DEPTH];
	logic                       out_valid_q;
	logic [VW-1:0]              out_value_q;
	logic                       out_sat_q;
	logic                       out_err_q;

	wbsa_pkg::cmd_t             head_cmd;
	logic [AW-1:0]              head_addr;
	logic [VW-1:0]              head_operand;
	logic                       out_free;
	logic                       mem_re;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [VW-1:0]              mem_wdata;
	logic [VW-1:0]              sum;
	logic                       overflow;
	logic [VW-1:0]              new_value;
	logic                       new_sat;
	logic                       finish_rmw;
	logic                       finish_err;

	// Unpack the queue head.
	assign head_cmd     = wbsa_pkg::cmd_t'(q_head[EW-1 -: wbsa_pkg::CMD_W]);
	assign head_addr    = q_head[VW +: AW];
	assign head_operand = q_head[VW-1:0];

	assign out_free = !out_valid_q || out_ch.ready;
	assign clearing = (state_q == ST_CLEAR);

	// Saturating add of the product to the stored entry.
	assign sum      = rd_data_q + operand_q;
	assign overflow = (rd_data_q[VW-1] == operand_q[VW-1]) && (sum[VW-1] != rd_data_q[VW-1]);

	// Value of the entry after the operation.
	always_comb begin
		new_value = rd_data_q;
		new_sat   = 1'b0;
		case (cmd_q)
			wbsa_pkg::CMD_ACC: begin
				if (overflow) begin
					new_value = rd_data_q[VW-1] ? wbsa_pkg::VAL_MIN : wbsa_pkg::VAL_MAX;
					new_sat   = 1'b1;
				end else begin
					new_value = sum;
				end
			end
			wbsa_pkg::CMD_WRITE: begin
				new_value = operand_q;
			end
			default: begin
				new_value = rd_data_q;
			end
		endcase
	end

	// Sequencer handshakes.
	assign finish_rmw = (state_q == ST_RMW) && out_free;
	assign finish_err = (state_q == ST_IDLE) && q_valid &&
		(head_cmd == wbsa_pkg::CMD_ERR) && out_free;
	assign mem_re     = (state_q == ST_IDLE) && q_valid && (head_cmd != wbsa_pkg::CMD_ERR);
	assign q_pop      = mem_re || finish_err;

	// Memory write port: zeroes during the clearing pass, results afterwards.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = new_value;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (finish_rmw &&
			(cmd_q == wbsa_pkg::CMD_ACC || cmd_q == wbsa_pkg::CMD_WRITE)) begin
			mem_we = 1'b1;
		end
	end

	// Accumulator memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[head_addr];
		end
	end

	// Item latched for the read-modify-write.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			cmd_q     <= head_cmd;
			addr_q    <= head_addr;
			operand_q <= head_operand;
		end
	end

	// State, clearing counter and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_sat_q   <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (finish_rmw) begin
				out_valid_q <= 1'b1;
				out_value_q <= new_value;
				out_sat_q   <= new_sat;
				out_err_q   <= 1'b0;
			end else if (finish_err) begin
				out_valid_q <= 1'b1;
				out_value_q <= '0;
				out_sat_q   <= 1'b0;
				out_err_q   <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (mem_re) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					if (finish_rmw) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.entry_value = out_value_q;
	assign out_ch.saturated   = out_sat_q;
	assign out_ch.index_error = out_err_q;

endmodule

// ===== rtl/weighted_block_scatter_accumulate_unit.sv =====
// Weighted block scatter-accumulate unit.
// Items arrive on in_ch (valid/ready) and name an operation on one entry of a
// square matrix of signed Q24.40 values: accumulate weight times coefficient,
// write a load value, or read. Each item yields exactly one result item on
// out_ch: the entry after the operation, a saturation flag and an index
// error flag. Items with an index outside the configured size change nothing.
// The matrix size register is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// After reset a clearing pass zeroes all MAX_GROUPS*MAX_GROUPS entries (4096
// at the default), one entry per cycle; in_ch.ready stays low meanwhile.
// An accepted item waits in a two-entry queue. The back reads the entry while
// idle, then updates it and fills the result register once that is free;
// an index error goes from the queue straight to the result register.
// A result waits in the output register while out_ch.ready is low; the queue
// keeps taking items until it is full, then in_ch.ready falls.
// Depends on wbsa_pkg, wbsa_if, wbsa_front, wbsa_queue and wbsa_back.
module weighted_block_scatter_accumulate_unit #(
	parameter int MAX_GROUPS = wbsa_pkg::MAX_GROUPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wbsa_pkg::SIZE_W-1:0] cfg_wdata,
	wbsa_in_if.sink                     in_ch,
	wbsa_out_if.source                  out_ch
);

	localparam int AW = $clog2(MAX_GROUPS * MAX_GROUPS);
	localparam int EW = wbsa_pkg::CMD_W + AW + wbsa_pkg::VAL_W;

	logic          clearing;
	logic          q_full;
	logic          q_push;
	logic [EW-1:0] q_data;
	logic          q_valid;
	logic [EW-1:0] q_head;
	logic          q_pop;

	// Classification and operand forming.
	wbsa_front #(
		.MAX_GROUPS (MAX_GROUPS),
		.AW         (AW),
		.EW         (EW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.clearing  (clearing),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	// Queue between front and back.
	wbsa_queue #(
		.W (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Memory update and results.
	wbsa_back #(
		.MAX_GROUPS (MAX_GROUPS),
		.AW         (AW),
		.EW         (EW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.out_ch   (out_ch)
	);

endmodule
